@@ rtl/shah_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shah_pkg
// shared types and constants for the sha-1 / sha-224 / sha-256 hash core
// ----------------------------------------------------------------------------
package shah_pkg;

  localparam logic [1:0] MODE_SHA1   = 2'd0;
  localparam logic [1:0] MODE_SHA224 = 2'd1;
  localparam logic [1:0] MODE_SHA256 = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] digest_byte;
    logic       digest_last;
  } out_item_t;

  // queue entry: a byte and/or a finish request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       finish;
  } cmd_t;

  localparam int QDEPTH = 2;

  function automatic logic [31:0] k256(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    return k[i];
  endfunction

  function automatic logic [31:0] iv(input logic [1:0] mode, input logic [2:0] i);
    logic [31:0] a [8];
    logic [31:0] b [8];
    logic [31:0] c [8];
    a = '{32'h67452301,32'hefcdab89,32'h98badcfe,32'h10325476,32'hc3d2e1f0,32'h0,32'h0,32'h0};
    b = '{32'hc1059ed8,32'h367cd507,32'h3070dd17,32'hf70e5939,32'hffc00b31,32'h68581511,
          32'h64f98fa7,32'hbefa4fa4};
    c = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,32'h510e527f,32'h9b05688c,
          32'h1f83d9ab,32'h5be0cd19};
    if (mode == MODE_SHA1) return a[i];
    else if (mode == MODE_SHA224) return b[i];
    else return c[i];
  endfunction

endpackage

@@ rtl/shah_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shah_front
// accepts input transactions and queues them as commands for the engine
// ----------------------------------------------------------------------------
module shah_front (
  input  logic                clk,
  input  logic                rst,
  input  shah_pkg::in_item_t  in_data,
  input  logic                in_valid,
  output logic                in_ready,
  output shah_pkg::cmd_t      cmd,
  output logic                cmd_valid,
  input  logic                cmd_ready
);

  shah_pkg::cmd_t q [shah_pkg::QDEPTH];
  logic       wp, rp;
  logic [1:0] count;
  logic       push, pop, useful;

  // an item with neither byte nor finish is dropped here
  assign useful    = in_data.byte_present | in_data.end_of_message;
  assign in_ready  = (count != 2'd2);
  assign push      = in_valid & in_ready & useful;
  assign cmd_valid = (count != 2'd0);
  assign pop       = cmd_valid & cmd_ready;
  assign cmd       = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      q[wp] <= '{data_byte: in_data.data_byte, has_byte: in_data.byte_present,
                 finish: in_data.end_of_message};
    end
  end

  always_comb begin
    if (!rst && count > 2'd2) $error("queue overflow");
  end

  assert property (@(posedge clk) disable iff (rst) count == 2'd2 |-> !in_ready)
    else $error("ready while full");
  assert property (@(posedge clk) disable iff (rst) count == 2'd0 |-> !cmd_valid)
    else $error("valid while empty");
  assert property (@(posedge clk) disable iff (rst) push && !pop |=> count != 2'd0)
    else $error("push lost");

endmodule

@@ rtl/shah_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shah_engine
// block buffer, padding, one round per cycle compression and digest output
// ----------------------------------------------------------------------------
module shah_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_mode,
  input  shah_pkg::cmd_t      cmd,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  output shah_pkg::out_item_t out_data,
  output logic                out_valid,
  input  logic                out_ready
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_RUN, S_ADD, S_OUT
  } state_t;

  state_t      state;
  logic [1:0]  mode;
  logic [31:0] h [8];
  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [5:0]  fill;
  logic [63:0] total;
  logic [6:0]  rnd;
  logic [5:0]  pad_idx;
  logic        finishing;   // padding in progress, digest follows
  logic        len_done;    // the final block carries the length
  logic [4:0]  obyte;

  logic        is_sha1;
  logic [6:0]  last_rnd;
  logic [31:0] w_new, w_cur, t1, t2, f1, t_sha1, kk;
  logic [4:0]  nbytes;
  logic [31:0] oword;

  assign is_sha1  = (mode == shah_pkg::MODE_SHA1);
  assign last_rnd = is_sha1 ? 7'd79 : 7'd63;
  assign nbytes   = is_sha1 ? 5'd19 : (mode == shah_pkg::MODE_SHA224) ? 5'd27 : 5'd31;

  // schedule word for rounds 16 and up; w[0] is the oldest
  always_comb begin
    logic [31:0] s0, s1, x;
    s0 = {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ (w[1] >> 3);
    s1 = {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]} ^ (w[14] >> 10);
    x  = w[13] ^ w[8] ^ w[2] ^ w[0];
    if (is_sha1) w_new = {x[30:0], x[31]};
    else w_new = s1 + w[9] + s0 + w[0];
  end
  assign w_cur = (rnd < 7'd16) ? w[rnd[3:0]] : w_new;

  always_comb begin
    logic [31:0] ep, ch, ap, mj;
    if (rnd < 7'd20) kk = 32'h5a827999;
    else if (rnd < 7'd40) kk = 32'h6ed9eba1;
    else if (rnd < 7'd60) kk = 32'h8f1bbcdc;
    else kk = 32'hca62c1d6;
    if (rnd < 7'd20) f1 = (v[1] & v[2]) | (~v[1] & v[3]);
    else if (rnd < 7'd40 || rnd >= 7'd60) f1 = v[1] ^ v[2] ^ v[3];
    else f1 = (v[1] & v[2]) | (v[1] & v[3]) | (v[2] & v[3]);
    t_sha1 = {v[0][26:0], v[0][31:27]} + f1 + v[4] + kk + w_cur;
    ep = {v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]} ^ {v[4][24:0], v[4][31:25]};
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    ap = {v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]} ^ {v[0][21:0], v[0][31:22]};
    mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1 = v[7] + ep + ch + shah_pkg::k256(rnd[5:0]) + w_cur;
    t2 = ap + mj;
  end

  assign cmd_ready = (state == S_IDLE);
  assign oword = h[obyte[4:2]];
  always_comb begin
    case (obyte[1:0])
      2'd0: out_data.digest_byte = oword[31:24];
      2'd1: out_data.digest_byte = oword[23:16];
      2'd2: out_data.digest_byte = oword[15:8];
      default: out_data.digest_byte = oword[7:0];
    endcase
  end
  assign out_data.digest_last = (obyte == nbytes);
  assign out_valid = (state == S_OUT);

  // places a byte into the big-endian word buffer
  function automatic logic [31:0] put(input logic [31:0] wd, input logic [1:0] p,
                                      input logic [7:0] b);
    logic [31:0] r;
    r = wd;
    case (p)
      2'd0: r[31:24] = b;
      2'd1: r[23:16] = b;
      2'd2: r[15:8]  = b;
      default: r[7:0] = b;
    endcase
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode <= shah_pkg::MODE_SHA256;
      for (int i = 0; i < 8; i++) h[i] <= shah_pkg::iv(shah_pkg::MODE_SHA256, 3'(i));
      fill <= '0;
      total <= '0;
      finishing <= 1'b0;
      len_done <= 1'b0;
      rnd <= '0;
      obyte <= '0;
      pad_idx <= '0;
    end else if (cfg_we) begin
      mode <= (cfg_mode == 2'd3) ? shah_pkg::MODE_SHA256 : cfg_mode;
      for (int i = 0; i < 8; i++)
        h[i] <= shah_pkg::iv((cfg_mode == 2'd3) ? shah_pkg::MODE_SHA256 : cfg_mode, 3'(i));
      fill <= '0;
      total <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.has_byte) begin
              w[fill[5:2]] <= put(w[fill[5:2]], fill[1:0], cmd.data_byte);
              total <= total + 64'd8;
              fill <= fill + 6'd1;
            end
            finishing <= cmd.finish;
            len_done <= 1'b0;
            if (cmd.has_byte && fill == 6'd63) begin
              for (int i = 0; i < 8; i++) v[i] <= h[i];
              rnd <= '0;
              state <= S_RUN;
            end else if (cmd.finish) begin
              pad_idx <= cmd.has_byte ? fill + 6'd1 : fill;
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // one byte per cycle: marker at fill, zeros, then length in the tail
          if (pad_idx == fill && !len_done) begin
            w[pad_idx[5:2]] <= put(w[pad_idx[5:2]], pad_idx[1:0], 8'h80);
          end else if (pad_idx >= 6'd56 && len_done) begin
            w[pad_idx[5:2]] <= put(w[pad_idx[5:2]], pad_idx[1:0],
                                   total[8'd63 - {pad_idx[2:0], 3'b000} -: 8]);
          end else begin
            w[pad_idx[5:2]] <= put(w[pad_idx[5:2]], pad_idx[1:0], 8'h00);
          end
          if (pad_idx == 6'd63) begin
            for (int i = 0; i < 8; i++) v[i] <= h[i];
            rnd <= '0;
            state <= S_RUN;
          end
          pad_idx <= pad_idx + 6'd1;
        end
        S_RUN: begin
          if (rnd >= 7'd16) begin
            for (int i = 0; i < 15; i++) w[i] <= w[i+1];
            w[15] <= w_new;
          end
          if (is_sha1) begin
            v[0] <= t_sha1; v[1] <= v[0]; v[2] <= {v[1][1:0], v[1][31:2]};
            v[3] <= v[2]; v[4] <= v[3];
          end else begin
            v[0] <= t1 + t2; v[1] <= v[0]; v[2] <= v[1]; v[3] <= v[2];
            v[4] <= v[3] + t1; v[5] <= v[4]; v[6] <= v[5]; v[7] <= v[6];
          end
          rnd <= rnd + 7'd1;
          if (rnd == last_rnd) state <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) begin
            if (!is_sha1 || i < 5) h[i] <= h[i] + v[i];
          end
          if (!finishing) begin
            fill <= '0;
            state <= S_IDLE;
          end else if (len_done) begin
            fill <= '0;
            obyte <= '0;
            state <= S_OUT;
          end else begin
            // extra block: a full block opens it with the marker, otherwise
            // the marker already sits in the block just hashed
            pad_idx <= 6'd0;
            if (fill != 6'd0) len_done <= 1'b1;
            state <= S_PAD;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            obyte <= obyte + 5'd1;
            if (obyte == nbytes) begin
              for (int i = 0; i < 8; i++) h[i] <= shah_pkg::iv(mode, 3'(i));
              fill <= '0;
              total <= '0;
              finishing <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      // a padded block whose tail has room takes the length immediately
      if (state == S_PAD && pad_idx == fill && fill < 6'd56) len_done <= 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> finishing)
    else $error("digest without finish");
  assert property (@(posedge clk) disable iff (rst) state == S_RUN |-> rnd <= last_rnd)
    else $error("round overrun");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.digest_last |=> state == S_IDLE)
    else $error("no return to idle");

endmodule

@@ rtl/sha1_sha224_sha256_hash_core.sv @@
`timescale 1ns / 1ps
// compression: a byte that fills a block starts 80 (sha-1) or 64 (sha-224/256) rounds
// finish: byte-wise padding, one or two compressions, then 20/28/32 digest bytes
// input: bytes wait in a two-entry queue while the single shared round unit is busy
// reset: synchronous, loads sha-256 initial values and an empty message
// ----------------------------------------------------------------------------
// sha1_sha224_sha256_hash_core
// streaming sha-1 / sha-224 / sha-256 hash with byte input and byte digest output
// ----------------------------------------------------------------------------
module sha1_sha224_sha256_hash_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_data,
  input  shah_pkg::in_item_t  in_data,
  input  logic                in_valid,
  output logic                in_ready,
  output shah_pkg::out_item_t out_data,
  output logic                out_valid,
  input  logic                out_ready
);

  shah_pkg::cmd_t cmd;
  logic           cmd_valid, cmd_ready;

  shah_front u_front (
    .clk, .rst, .in_data, .in_valid, .in_ready,
    .cmd, .cmd_valid, .cmd_ready
  );

  shah_engine u_engine (
    .clk, .rst, .cfg_we, .cfg_mode(cfg_data),
    .cmd, .cmd_valid, .cmd_ready,
    .out_data, .out_valid, .out_ready
  );

endmodule
